// ===== rtl/byt_pkg.sv =====
package byt_pkg;

	localparam int VEC_W = 40;
	localparam int ROT_W = 44;
	localparam int ANG_W = 32;
	localparam int RES_W = 34;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [31:0] cur_z;
		logic signed [31:0] off_x;
		logic signed [31:0] off_y;
		logic signed [31:0] off_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} result_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] rx;
		logic signed [ROT_W-1:0] ry;
		logic signed [31:0]      cx;
		logic signed [31:0]      cy;
		logic signed [31:0]      tz;
	} carry_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [ANG_W-1:0]        ang;
		logic                    zero;
		carry_t                  c;
	} vec_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [RES_W-1:0] r;
		logic signed [31:0]      cx;
		logic signed [31:0]      cy;
		logic signed [31:0]      tz;
	} rot_t;

	function automatic logic [ANG_W-1:0] atan_at(input int i);
		logic [ANG_W-1:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10431;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh007fffffff)
			r = 32'sh7fffffff;
		else if (v < -40'sh0080000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/byt_vec_cell.sv =====
module byt_vec_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  byt_pkg::vec_t in_data,
	output logic          out_valid,
	output byt_pkg::vec_t out_data
);

	localparam logic [byt_pkg::ANG_W-1:0] ATAN = byt_pkg::atan_at(IDX);

	byt_pkg::vec_t nxt;
	logic          y_pos;

	assign y_pos = !in_data.y[byt_pkg::VEC_W-1] && (|in_data.y);

	always_comb begin
		nxt = in_data;
		if (y_pos) begin
			nxt.x   = in_data.x + (in_data.y >>> IDX);
			nxt.y   = in_data.y - (in_data.x >>> IDX);
			nxt.ang = in_data.ang + ATAN;
		end else begin
			nxt.x   = in_data.x - (in_data.y >>> IDX);
			nxt.y   = in_data.y + (in_data.x >>> IDX);
			nxt.ang = in_data.ang - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

// ===== rtl/byt_rot_cell.sv =====
module byt_rot_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  byt_pkg::rot_t in_data,
	output logic          out_valid,
	output byt_pkg::rot_t out_data
);

	localparam logic signed [byt_pkg::RES_W-1:0] ATAN =
		$signed({2'b00, byt_pkg::atan_at(IDX)});

	byt_pkg::rot_t nxt;

	always_comb begin
		nxt = in_data;
		if (!in_data.r[byt_pkg::RES_W-1]) begin
			nxt.x = in_data.x - (in_data.y >>> IDX);
			nxt.y = in_data.y + (in_data.x >>> IDX);
			nxt.r = in_data.r - ATAN;
		end else begin
			nxt.x = in_data.x + (in_data.y >>> IDX);
			nxt.y = in_data.y - (in_data.x >>> IDX);
			nxt.r = in_data.r + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

// ===== rtl/body_to_local_yaw_transform_top.sv =====
// Body-frame offset to local-frame target, yaw-only rotation.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. busy is always low, so one transaction can enter per cycle.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall, so results are never held.
// Pipeline registers, in order: the multipliers, the yaw vector and scaled
//   offset, CORDIC_STAGES vectoring cells, one quadrant fold,
//   CORDIC_STAGES rotation cells, and the round, add and saturate stage.
// Throughput is one transaction per cycle, set by the row of CORDIC cells,
// each handing its result to the next one every clock.
// Reset clears every valid bit in the row; transactions in flight are lost
// and no done is raised until new transactions reach the end.
module body_to_local_yaw_transform_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  byt_pkg::item_t   item,
	output logic             done,
	output byt_pkg::result_t result
);

	localparam logic signed [31:0] GAIN_INV = 32'sd652032874;

	logic accepted;
	assign busy     = 1'b0;
	assign accepted = start && !busy;

	logic                 v_s1;
	logic signed [31:0]   pwz_s1, pxy_s1, pyy_s1, pzz_s1;
	logic signed [63:0]   pox_s1, poy_s1;
	logic signed [31:0]   cx_s1, cy_s1, tz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accepted;
	end

	always_ff @(posedge clk) begin
		pwz_s1 <= item.quat_w * item.quat_z;
		pxy_s1 <= item.quat_x * item.quat_y;
		pyy_s1 <= item.quat_y * item.quat_y;
		pzz_s1 <= item.quat_z * item.quat_z;
		pox_s1 <= 64'(item.off_x) * 64'(GAIN_INV);
		poy_s1 <= 64'(item.off_y) * 64'(GAIN_INV);
		cx_s1  <= item.cur_x;
		cy_s1  <= item.cur_y;
		tz_s1  <= byt_pkg::sat32(40'(item.cur_z) + 40'(item.off_z));
	end

	logic signed [byt_pkg::VEC_W-1:0] num, den;
	byt_pkg::vec_t                    vin;

	always_comb begin
		num = (40'(pwz_s1) + 40'(pxy_s1)) <<< 1;
		den = 40'sd268435456 - ((40'(pyy_s1) + 40'(pzz_s1)) <<< 1);
		vin.zero = (num == '0) && (den == '0);
		if (den[byt_pkg::VEC_W-1]) begin
			vin.x   = -den;
			vin.y   = -num;
			vin.ang = 32'h80000000;
		end else begin
			vin.x   = den;
			vin.y   = num;
			vin.ang = '0;
		end
		vin.c.rx = byt_pkg::ROT_W'($signed(pox_s1[63:22]));
		vin.c.ry = byt_pkg::ROT_W'($signed(poy_s1[63:22]));
		vin.c.cx = cx_s1;
		vin.c.cy = cy_s1;
		vin.c.tz = tz_s1;
	end

	logic          v_s2;
	byt_pkg::vec_t vec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		vec_s2 <= vin;
	end

	logic          vv   [CORDIC_STAGES+1];
	byt_pkg::vec_t vbus [CORDIC_STAGES+1];

	assign vv[0]   = v_s2;
	assign vbus[0] = vec_s2;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
		byt_vec_cell #(.IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vv[g]),
			.in_data  (vbus[g]),
			.out_valid(vv[g+1]),
			.out_data (vbus[g+1])
		);
	end

	byt_pkg::vec_t                    vend;
	logic signed [byt_pkg::RES_W-1:0] r0;
	byt_pkg::rot_t                    rin;

	assign vend = vbus[CORDIC_STAGES];

	always_comb begin
		r0 = vend.zero ? '0 : byt_pkg::RES_W'($signed(vend.ang));
		rin.x  = vend.c.rx;
		rin.y  = vend.c.ry;
		rin.r  = r0;
		rin.cx = vend.c.cx;
		rin.cy = vend.c.cy;
		rin.tz = vend.c.tz;
		if (r0 > 34'sd1073741824) begin
			rin.x = -vend.c.rx;
			rin.y = -vend.c.ry;
			rin.r = r0 - 34'sd2147483648;
		end else if (r0 < -34'sd1073741824) begin
			rin.x = -vend.c.rx;
			rin.y = -vend.c.ry;
			rin.r = r0 + 34'sd2147483648;
		end
	end

	logic          v_s3;
	byt_pkg::rot_t rot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= vv[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		rot_s3 <= rin;
	end

	logic          rv   [CORDIC_STAGES+1];
	byt_pkg::rot_t rbus [CORDIC_STAGES+1];

	assign rv[0]   = v_s3;
	assign rbus[0] = rot_s3;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		byt_rot_cell #(.IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (rv[g]),
			.in_data  (rbus[g]),
			.out_valid(rv[g+1]),
			.out_data (rbus[g+1])
		);
	end

	byt_pkg::rot_t                    rend;
	logic signed [byt_pkg::ROT_W-1:0] rxh, ryh;

	assign rend = rbus[CORDIC_STAGES];
	assign rxh  = rend.x + 44'sd128;
	assign ryh  = rend.y + 44'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= rv[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		result.out_x <= byt_pkg::sat32(40'(rend.cx) + 40'($signed(rxh[43:8])));
		result.out_y <= byt_pkg::sat32(40'(rend.cy) + 40'($signed(ryh[43:8])));
		result.out_z <= rend.tz;
	end

endmodule

// ===== rtl/byt_check.sv =====
module byt_check #(
	parameter int STAGES = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input byt_pkg::item_t   item,
	input logic             done,
	input byt_pkg::result_t result
);

	localparam int LAT = 2 * STAGES + 4;

	logic               accepted;
	logic [7:0]         age_q;
	logic               warm;
	logic signed [31:0] exp_z;

	assign accepted = start && !busy;
	assign warm     = (age_q >= 8'(LAT));
	assign exp_z    = byt_pkg::sat32(40'(item.cur_z) + 40'(item.off_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			age_q <= '0;
		else if (!warm)
			age_q <= age_q + 8'd1;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accepted |-> ##LAT done)
		else $error("transaction did not complete at fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(done && warm) |-> $past(accepted, LAT))
		else $error("done without a matching transaction");

	a_z_path: assert property (@(posedge clk) disable iff (!arst_n)
		(done && warm) |-> (result.out_z == $past(exp_z, LAT)))
		else $error("out_z mismatch");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind body_to_local_yaw_transform_top byt_check #(.STAGES(CORDIC_STAGES)) u_byt_check (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int STAGES = 16;
	localparam int LATENCY = 2 * STAGES + 4;
	localparam logic [31:0] GAIN_INV = 32'd652032874;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	byt_pkg::item_t item = '0;
	logic done;
	byt_pkg::result_t result;

	byt_pkg::result_t pending_targets[$];
	int errors = 0;
	bit calm = 1'b0;

	body_to_local_yaw_transform_top #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] atan_entry(int i);
		logic [31:0] tab [32] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10431, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return tab[i];
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic byt_pkg::result_t target_of(byt_pkg::item_t it);
		longint qx, qy, qz, qw, num, den, x, y, nx, ny, rx, ry, r;
		logic [31:0] yaw;
		byt_pkg::result_t res;
		qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
		num = 2 * (qw * qz + qx * qy);
		den = 64'sd268435456 - 2 * (qy * qy + qz * qz);
		yaw = '0;
		x = den; y = num;
		if (!(x == 0 && y == 0)) begin
			if (x < 0) begin
				x = -x; y = -y; yaw = 32'h80000000;
			end
			for (int i = 0; i < STAGES; i++) begin
				if (y > 0) begin
					nx = x + floor_shift(y, i); ny = y - floor_shift(x, i);
					yaw += atan_entry(i);
				end else begin
					nx = x - floor_shift(y, i); ny = y + floor_shift(x, i);
					yaw -= atan_entry(i);
				end
				x = nx; y = ny;
			end
		end
		rx = floor_shift(longint'(it.off_x) * longint'(GAIN_INV), 22);
		ry = floor_shift(longint'(it.off_y) * longint'(GAIN_INV), 22);
		r = longint'(signed'(yaw));
		if (r > 64'sd1073741824) begin
			rx = -rx; ry = -ry; r -= 64'sd2147483648;
		end else if (r < -64'sd1073741824) begin
			rx = -rx; ry = -ry; r += 64'sd2147483648;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (r >= 0) begin
				nx = rx - floor_shift(ry, i); ny = ry + floor_shift(rx, i);
				r -= atan_entry(i);
			end else begin
				nx = rx + floor_shift(ry, i); ny = ry - floor_shift(rx, i);
				r += atan_entry(i);
			end
			rx = nx; ry = ny;
		end
		res.out_x = clamp32(longint'(it.cur_x) + floor_shift(rx + 128, 8));
		res.out_y = clamp32(longint'(it.cur_y) + floor_shift(ry + 128, 8));
		res.out_z = clamp32(longint'(it.cur_z) + longint'(it.off_z));
		return res;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (pending_targets.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				byt_pkg::result_t want;
				want = pending_targets.pop_front();
				if (result.out_x !== want.out_x) begin
					$display("%0t: out_x expected %h actual %h",
						$time, want.out_x, result.out_x);
					errors++;
				end
				if (result.out_y !== want.out_y) begin
					$display("%0t: out_y expected %h actual %h",
						$time, want.out_y, result.out_y);
					errors++;
				end
				if (result.out_z !== want.out_z) begin
					$display("%0t: out_z expected %h actual %h",
						$time, want.out_z, result.out_z);
					errors++;
				end
			end
		end
	end

	task automatic send_pose(byt_pkg::item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pending_targets.push_back(target_of(it));
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_q(int mode);
		case (mode)
			0: return 16'($urandom_range(0, 32768) - 16384);
			1: return 16'($urandom);
			default: return 16'($urandom_range(0, 2048) - 1024);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_pos(int mode);
		case (mode)
			0: return 32'($urandom);
			1: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	function automatic byt_pkg::item_t make_pose(int qx, int qy, int qz, int qw,
			int cx, int cy, int cz, int ox, int oy, int oz);
		byt_pkg::item_t it;
		it.quat_x = 16'(qx); it.quat_y = 16'(qy); it.quat_z = 16'(qz); it.quat_w = 16'(qw);
		it.cur_x = cx; it.cur_y = cy; it.cur_z = cz;
		it.off_x = ox; it.off_y = oy; it.off_z = oz;
		return it;
	endfunction

	task automatic test_directed();
		int one = 32'sh0001_0000;
		send_pose(make_pose(0, 0, 0, 16384, 0, 0, 0, one, 0, one));
		send_pose(make_pose(0, 0, 0, 0, 100, 200, 300, one, one, -one));
		send_pose(make_pose(0, 0, 16384, 0, 0, 0, 0, one, one, 0));
		send_pose(make_pose(0, 0, 11585, 11585, 0, 0, 0, one, 0, 0));
		send_pose(make_pose(0, 0, 11585, -11585, 0, 0, 0, one, 0, 0));
		send_pose(make_pose(0, 0, -11585, 11585, 0, 0, 0, 0, one, 0));
		send_pose(make_pose(0, 16384, 0, 0, 5, 5, 5, one, one, one));
		send_pose(make_pose(16384, 16384, 0, 0, 0, 0, 0, one, 0, 0));
		send_pose(make_pose(-16384, -16384, -16384, -16384, 0, 0, 0, one, one, one));
		send_pose(make_pose(-32768, -32768, -32768, -32768, 0, 0, 0, one, one, one));
		send_pose(make_pose(32767, 32767, 32767, 32767, 0, 0, 0, -one, one, -one));
		send_pose(make_pose(0, 0, 16384, 1, 0, 0, 0, one, 0, 0));
		send_pose(make_pose(0, 0, 16384, -1, 0, 0, 0, one, 0, 0));
		send_pose(make_pose(0, 0, 0, 16384, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		send_pose(make_pose(0, 0, 0, 16384, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_pose(make_pose(0, 0, 16384, 0, 32'sh7fffffff, 32'sh80000000, -1,
			32'sh80000000, 32'sh7fffffff, 1));
		send_pose(make_pose(0, 0, 0, 16384, -1, -1, -1, -1, -1, -1));
		send_pose(make_pose(0, 0, 11585, 11585, 32'sh80000000, 32'sh7fffffff, 0,
			32'sh7fffffff, 32'sh7fffffff, 0));
	endtask

	task automatic test_random(int count);
		byt_pkg::item_t it;
		int qm, pm;
		for (int n = 0; n < count; n++) begin
			qm = $urandom_range(0, 4);
			pm = $urandom_range(0, 4);
			it.quat_x = rand_q(qm); it.quat_y = rand_q(qm);
			it.quat_z = rand_q(qm); it.quat_w = rand_q(qm);
			it.cur_x = rand_pos(pm); it.cur_y = rand_pos(pm); it.cur_z = rand_pos(pm);
			it.off_x = rand_pos(pm); it.off_y = rand_pos(pm); it.off_z = rand_pos(pm);
			if (pm == 4) begin
				it.cur_x = rand_pos(0); it.off_y = rand_pos(0);
			end
			send_pose(it);
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1600);
		calm = 1'b1;
		test_random(250);
		start <= 1'b0;
		wait_cycles = 0;
		while (pending_targets.size() != 0 && wait_cycles < 10 * LATENCY + 100) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_targets.size() != 0) begin
			$display("%0t: %0d results missing", $time, pending_targets.size());
			errors++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
